FILE: hw/rtl/prq_pkg.sv
package prq_pkg;

  localparam int CmdW    = 2;
  localparam int IdW     = 7;
  localparam int PrioW   = 3;
  localparam int StatusW = 2;
  localparam int CountW  = 8;

  localparam int DefNumEntries     = 128;
  localparam int DefPriorityLevels = 8;

  localparam logic [CmdW-1:0] CMD_ADD    = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_CHANGE = 2'd2;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_NO_FREE  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY    = 2'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd3;

  // decoded command word handed from front to back
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [IdW-1:0]   id;
    logic             id_ok;
    logic [PrioW-1:0] prio;
  } prq_cmd_t;

endpackage

FILE: hw/rtl/priority_ready_queue.sv
// Channel   Handshake           Word
// input     in_valid/in_stall   command, proc_id, new_priority
// output    out_valid/out_stall status, result_id, result_priority, queue_count
//
// A two-word command queue sits ahead of the list engine, so input is taken
// while a result waits; input stalls once both slots are full, and a stalled
// result holds the engine. Remove reads the head entry's link; add takes a
// never-used entry or reads a reused entry's free link, then compares queued
// entries in order and links behind one; change searches, unlinks, then inserts.
// Reset is synchronous; no clearing pass, never-used entries come from a fill pointer.
module priority_ready_queue #(
  parameter int NUM_ENTRIES     = prq_pkg::DefNumEntries,
  parameter int PRIORITY_LEVELS = prq_pkg::DefPriorityLevels
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [prq_pkg::CmdW-1:0]      command,
  input  logic [prq_pkg::IdW-1:0]       proc_id,
  input  logic [prq_pkg::PrioW-1:0]     new_priority,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [prq_pkg::StatusW-1:0]   status,
  output logic [prq_pkg::IdW-1:0]       result_id,
  output logic [prq_pkg::PrioW-1:0]     result_priority,
  output logic [prq_pkg::CountW-1:0]    queue_count
);
  import prq_pkg::*;

  logic     q_valid;
  logic     q_pop;
  prq_cmd_t q_item;

  prq_front #(
    .NUM_ENTRIES     (NUM_ENTRIES),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .proc_id      (proc_id),
    .new_priority (new_priority),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  prq_back #(
    .NUM_ENTRIES     (NUM_ENTRIES),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .result_id       (result_id),
    .result_priority (result_priority),
    .queue_count     (queue_count)
  );

endmodule

FILE: hw/rtl/prq_front.sv
module prq_front #(
  parameter int NUM_ENTRIES     = prq_pkg::DefNumEntries,
  parameter int PRIORITY_LEVELS = prq_pkg::DefPriorityLevels
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [prq_pkg::CmdW-1:0]    command,
  input  logic [prq_pkg::IdW-1:0]     proc_id,
  input  logic [prq_pkg::PrioW-1:0]   new_priority,
  output logic                        q_valid,
  output prq_pkg::prq_cmd_t           q_item,
  input  logic                        q_pop
);
  import prq_pkg::*;

  localparam int QD = 2;

  prq_cmd_t       q [QD];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  prq_cmd_t       dec;
  logic           push;

  always_comb begin
    dec.cmd   = command;
    dec.id    = proc_id;
    dec.id_ok = 32'(proc_id) < NUM_ENTRIES;
    // saturate priorities beyond the configured range
    dec.prio  = (32'(new_priority) >= PRIORITY_LEVELS) ? PrioW'(PRIORITY_LEVELS - 1)
                                                        : new_priority;
  end

  assign in_stall = (fill == 2'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= 2'(fill + {1'b0, push} - {1'b0, q_pop});
    end
  end

endmodule

FILE: hw/rtl/prq_back.sv
module prq_back #(
  parameter int NUM_ENTRIES     = prq_pkg::DefNumEntries,
  parameter int PRIORITY_LEVELS = prq_pkg::DefPriorityLevels
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  prq_pkg::prq_cmd_t             q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [prq_pkg::StatusW-1:0]   status,
  output logic [prq_pkg::IdW-1:0]       result_id,
  output logic [prq_pkg::PrioW-1:0]     result_priority,
  output logic [prq_pkg::CountW-1:0]    queue_count
);
  import prq_pkg::*;

  localparam int NW = $clog2(NUM_ENTRIES + 1);
  localparam int AW = $clog2(NUM_ENTRIES);
  localparam int PW = $clog2(PRIORITY_LEVELS);
  localparam logic [NW-1:0] NIL = NW'(NUM_ENTRIES);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ADD_RD  = 3'd1;
  localparam logic [2:0] S_REM_RD  = 3'd2;
  localparam logic [2:0] S_FIND    = 3'd3;
  localparam logic [2:0] S_UNLINK  = 3'd4;
  localparam logic [2:0] S_INS     = 3'd5;
  localparam logic [2:0] S_INS_CMP = 3'd6;
  localparam logic [2:0] S_LINK    = 3'd7;

  logic [NW-1:0] link_mem [NUM_ENTRIES];
  logic [PW-1:0] prio_mem [NUM_ENTRIES];
  logic [NW-1:0] rd_link;
  logic [PW-1:0] rd_prio;
  logic [AW-1:0] rd_addr;
  logic          link_we;
  logic [AW-1:0] link_wa;
  logic [NW-1:0] link_wd;
  logic          prio_we;
  logic [AW-1:0] prio_wa;
  logic [PW-1:0] prio_wd;

  logic [2:0]      state, state_next;
  logic [NW-1:0]   head, head_next;
  logic [NW-1:0]   free_head, free_head_next;
  logic [NW-1:0]   fresh, fresh_next;      // entries at and above fresh were never allocated
  logic [NW-1:0]   count, count_next;
  logic [NW-1:0]   trail, trail_next;
  logic [NW-1:0]   cur, cur_next;
  logic [NW-1:0]   ent, ent_next;
  logic [CmdW-1:0] op_cmd, op_cmd_next;
  logic [NW-1:0]   op_id, op_id_next;
  logic [PW-1:0]   op_pr, op_pr_next;
  logic            out_valid_next;
  logic [StatusW-1:0] out_status, out_status_next;
  logic [NW-1:0]   out_id, out_id_next;
  logic [PW-1:0]   out_pr, out_pr_next;
  logic [NW-1:0]   out_count, out_count_next;

  logic            fin;
  logic [StatusW-1:0] fin_status;
  logic [NW-1:0]   fin_id;
  logic [PW-1:0]   fin_pr;
  logic            fin_ins;
  logic            do_place;
  logic [NW-1:0]   pl_trail;
  logic [NW-1:0]   pl_cur;
  logic [NW-1:0]   item_id;

  assign item_id = q_item.id_ok ? NW'(q_item.id) : NIL;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (prio_we) begin
      prio_mem[prio_wa] <= prio_wd;
    end
    rd_link <= link_mem[rd_addr];
    rd_prio <= prio_mem[rd_addr];
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    free_head_next  = free_head;
    fresh_next      = fresh;
    count_next      = count;
    trail_next      = trail;
    cur_next        = cur;
    ent_next        = ent;
    op_cmd_next     = op_cmd;
    op_id_next      = op_id;
    op_pr_next      = op_pr;
    out_valid_next  = out_valid && out_stall;
    out_status_next = out_status;
    out_id_next     = out_id;
    out_pr_next     = out_pr;
    out_count_next  = out_count;
    rd_addr  = '0;
    link_we  = 1'b0;
    link_wa  = '0;
    link_wd  = '0;
    prio_we  = 1'b0;
    prio_wa  = '0;
    prio_wd  = '0;
    q_pop    = 1'b0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_id     = '0;
    fin_pr     = '0;
    fin_ins    = 1'b0;
    do_place   = 1'b0;
    pl_trail   = NIL;
    pl_cur     = NIL;

    unique case (state)
      S_IDLE: begin
        if (q_valid && !out_valid) begin
          q_pop       = 1'b1;
          op_cmd_next = q_item.cmd;
          op_id_next  = item_id;
          op_pr_next  = PW'(q_item.prio);
          unique case (q_item.cmd)
            CMD_ADD: begin
              if (free_head == NIL) begin
                fin        = 1'b1;
                fin_status = ST_NO_FREE;
              end else begin
                ent_next = free_head;
                prio_we  = 1'b1;
                prio_wa  = AW'(free_head);
                prio_wd  = PW'(q_item.prio);
                if (free_head == fresh) begin
                  free_head_next = NW'(fresh + 1'b1);
                  fresh_next     = NW'(fresh + 1'b1);
                  state_next     = S_INS;
                end else begin
                  rd_addr    = AW'(free_head);
                  state_next = S_ADD_RD;
                end
              end
            end
            CMD_REMOVE: begin
              if (head == NIL) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                ent_next   = head;
                rd_addr    = AW'(head);
                state_next = S_REM_RD;
              end
            end
            CMD_CHANGE: begin
              trail_next = NIL;
              cur_next   = head;
              rd_addr    = AW'(head);
              if (head == NIL) begin
                fin        = 1'b1;
                fin_status = ST_NOT_FOUND;
              end else if (head == item_id) begin
                state_next = S_UNLINK;
              end else begin
                state_next = S_FIND;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        free_head_next = rd_link;
        state_next     = S_INS;
      end
      S_REM_RD: begin
        head_next      = rd_link;
        link_we        = 1'b1;
        link_wa        = AW'(ent);
        link_wd        = free_head;
        free_head_next = ent;
        count_next     = NW'(count - 1'b1);
        fin    = 1'b1;
        fin_id = ent;
        fin_pr = rd_prio;
      end
      S_FIND: begin
        // rd_link holds the successor of cur
        trail_next = cur;
        cur_next   = rd_link;
        rd_addr    = AW'(rd_link);
        if (rd_link == NIL) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
        end else if (rd_link == op_id) begin
          state_next = S_UNLINK;
        end
      end
      S_UNLINK: begin
        if (trail == NIL) begin
          head_next = rd_link;
        end else begin
          link_we = 1'b1;
          link_wa = AW'(trail);
          link_wd = rd_link;
        end
        prio_we    = 1'b1;
        prio_wa    = AW'(cur);
        prio_wd    = op_pr;
        ent_next   = cur;
        state_next = S_INS;
      end
      S_INS: begin
        if (head == NIL) begin
          do_place = 1'b1;
        end else begin
          trail_next = NIL;
          cur_next   = head;
          rd_addr    = AW'(head);
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        // rd_prio / rd_link belong to cur
        if (op_pr > rd_prio) begin
          do_place = 1'b1;
          pl_trail = trail;
          pl_cur   = cur;
        end else if (rd_link == NIL) begin
          do_place = 1'b1;
          pl_trail = cur;
        end else begin
          trail_next = cur;
          cur_next   = rd_link;
          rd_addr    = AW'(rd_link);
        end
      end
      S_LINK: begin
        link_we = 1'b1;
        link_wa = AW'(trail);
        link_wd = ent;
        fin_ins = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_place) begin
      link_we = 1'b1;
      link_wa = AW'(ent);
      link_wd = pl_cur;
      if (pl_trail == NIL) begin
        head_next = ent;
        fin_ins   = 1'b1;
      end else begin
        trail_next = pl_trail;
        state_next = S_LINK;
      end
    end

    if (fin_ins) begin
      fin    = 1'b1;
      fin_id = ent;
      fin_pr = op_pr;
      if (op_cmd == CMD_ADD) begin
        count_next = NW'(count + 1'b1);
      end
    end

    if (fin) begin
      state_next      = S_IDLE;
      out_valid_next  = 1'b1;
      out_status_next = fin_status;
      out_id_next     = fin_id;
      out_pr_next     = fin_pr;
      out_count_next  = count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      free_head <= '0;
      fresh     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    trail      <= trail_next;
    cur        <= cur_next;
    ent        <= ent_next;
    op_cmd     <= op_cmd_next;
    op_id      <= op_id_next;
    op_pr      <= op_pr_next;
    out_status <= out_status_next;
    out_id     <= out_id_next;
    out_pr     <= out_pr_next;
    out_count  <= out_count_next;
  end

  assign status          = out_status;
  assign result_id       = IdW'(out_id);
  assign result_priority = PrioW'(out_pr);
  assign queue_count     = CountW'(out_count);

endmodule

FILE: tb/prq_checker.sv
`timescale 1ns / 1ps
module prq_checker
  import prq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CmdW-1:0]    command,
  input  logic [IdW-1:0]     proc_id,
  input  logic [PrioW-1:0]   new_priority,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [StatusW-1:0] status,
  input  logic [IdW-1:0]     result_id,
  input  logic [PrioW-1:0]   result_priority,
  input  logic [CountW-1:0]  queue_count,
  output int                 fail_count,
  output int                 pending
);

  localparam int NENT = DefNumEntries;
  localparam int NIL = NENT;

  typedef struct packed {
    logic [StatusW-1:0] st;
    logic [IdW-1:0]     id;
    logic [PrioW-1:0]   pr;
    logic [CountW-1:0]  cnt;
  } answer_t;

  answer_t answers_due[$];

  int nxt [NENT];
  int prio [NENT];
  int rq_head, fr_head, rq_count;

  function automatic int link_after(int e);
    if (e >= NIL) return NIL;
    return nxt[e] < NIL ? nxt[e] : NIL;
  endfunction

  function automatic int prio_at(int e);
    return e < NIL ? prio[e] : 0;
  endfunction

  // slot e goes behind all queued entries of equal or higher priority
  task automatic place_ready(int e);
    int p, tr, cu;
    p = prio_at(e);
    if (rq_head >= NIL || p > prio_at(rq_head)) begin
      nxt[e] = rq_head;
      rq_head = e;
    end else begin
      tr = rq_head;
      cu = link_after(tr);
      while (cu < NIL && p <= prio_at(cu)) begin
        tr = cu;
        cu = link_after(cu);
      end
      nxt[tr] = e;
      nxt[e] = cu;
    end
  endtask

  task automatic clear_queue();
    for (int i = 0; i < NENT; i++) begin
      nxt[i] = i + 1;
      prio[i] = 0;
    end
    rq_head = NIL;
    fr_head = 0;
    rq_count = 0;
  endtask

  task automatic apply_command(logic [CmdW-1:0] c, logic [IdW-1:0] pid,
                               logic [PrioW-1:0] np);
    answer_t a;
    int e, tr, cu, p;
    p = (np >= DefPriorityLevels) ? DefPriorityLevels - 1 : np;
    a = '0;
    if (c == CMD_ADD) begin
      if (fr_head >= NIL) a.st = ST_NO_FREE;
      else begin
        e = fr_head;
        fr_head = link_after(e);
        prio[e] = p;
        place_ready(e);
        rq_count++;
        a.id = IdW'(e); a.pr = PrioW'(p);
      end
    end else if (c == CMD_REMOVE) begin
      if (rq_head >= NIL) a.st = ST_EMPTY;
      else begin
        e = rq_head;
        rq_head = link_after(e);
        nxt[e] = fr_head;
        fr_head = e;
        rq_count--;
        a.id = IdW'(e); a.pr = PrioW'(prio_at(e));
      end
    end else if (c == CMD_CHANGE) begin
      tr = NIL;
      cu = rq_head;
      while (cu < NIL && cu != pid) begin
        tr = cu;
        cu = link_after(cu);
      end
      if (cu >= NIL) a.st = ST_NOT_FOUND;
      else begin
        if (tr >= NIL) rq_head = link_after(cu);
        else nxt[tr] = link_after(cu);
        prio[cu] = p;
        place_ready(cu);
        a.id = IdW'(cu); a.pr = PrioW'(p);
      end
    end
    a.cnt = CountW'(rq_count);
    answers_due.push_back(a);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    clear_queue();
  end

  assign pending = answers_due.size();

  always @(posedge clk) begin
    answer_t w;
    if (rst) begin
      clear_queue();
      answers_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) report_mismatch("unexpected word", 1, 0);
        else begin
          w = answers_due.pop_front();
          if (status !== w.st) report_mismatch("status", status, w.st);
          if (result_id !== w.id) report_mismatch("result_id", result_id, w.id);
          if (result_priority !== w.pr)
            report_mismatch("result_priority", result_priority, w.pr);
          if (queue_count !== w.cnt) report_mismatch("queue_count", queue_count, w.cnt);
        end
      end
      if (in_valid && !in_stall) apply_command(command, proc_id, new_priority);
    end
  end

endmodule

FILE: tb/priority_ready_queue_tb.sv
`timescale 1ns / 1ps
module priority_ready_queue_tb;
  import prq_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CmdW-1:0]    command = '0;
  logic [IdW-1:0]     proc_id = '0;
  logic [PrioW-1:0]   new_priority = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     result_id;
  logic [PrioW-1:0]   result_priority;
  logic [CountW-1:0]  queue_count;
  int                 fail_count, pending;
  int                 idle_cycles = 0;
  bit                 hold_off = 1'b0;
  bit                 fast_sink = 1'b0;
  bit                 fast_src = 1'b0;

  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 400;
  // command code with no operation behind it
  localparam logic [CmdW-1:0] CmdSpare = 2'd3;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  priority_ready_queue u_top (.*);

  prq_checker u_chk (.*);

  task automatic send_word(logic [CmdW-1:0] c, logic [IdW-1:0] pid,
                           logic [PrioW-1:0] np);
    int gap;
    gap = fast_src ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    proc_id <= pid;
    new_priority <= np;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // receiver: random stalls, no stalls in fast mode, or one long hold when asked
  initial begin
    int s;
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        held = 1'b1;
        out_stall <= 1'b0;
      end else if (fast_sink) out_stall <= 1'b0;
      else begin
        s = $urandom_range(0, 19);
        if (s > 1 && $urandom_range(0, 2) == 0) begin
          out_stall <= 1'b1;
          repeat (s - 1) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** priority_ready_queue: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [CmdW-1:0] c;
    int r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty cases, extreme ids and priorities, unused code
    send_word(CMD_REMOVE, 7'd0, 3'd0);
    send_word(CMD_CHANGE, 7'd0, 3'd5);
    send_word(CmdSpare, 7'h7f, 3'd7);
    send_word(CMD_ADD, 7'h7f, 3'd0);
    send_word(CMD_ADD, 7'd0, 3'd7);
    send_word(CMD_ADD, 7'd0, 3'd7);
    send_word(CMD_ADD, 7'd0, 3'd3);
    send_word(CMD_CHANGE, 7'd0, 3'd7);
    send_word(CMD_CHANGE, 7'd3, 3'd7);
    send_word(CMD_CHANGE, 7'h7f, 3'd1);
    send_word(CMD_CHANGE, 7'd2, 3'd0);
    repeat (4) send_word(CMD_REMOVE, 7'd0, 3'd0);
    send_word(CmdSpare, 7'h55, 3'd2);
    // fill the pool past its size while the receiver holds off
    hold_off = 1'b1;
    fast_src = 1'b1;
    for (int i = 0; i < 132; i++) send_word(CMD_ADD, IdW'($urandom), PrioW'($urandom));
    fast_src = 1'b0;
    hold_off = 1'b0;
    for (int i = 0; i < 20; i++)
      send_word(CMD_CHANGE, IdW'($urandom_range(0, 127)), PrioW'($urandom));
    for (int i = 0; i < 130; i++) send_word(CMD_REMOVE, IdW'($urandom), PrioW'($urandom));
    drain();
    // random traffic in phases of differing add/remove balance
    for (int ph = 0; ph < 4; ph++) begin
      fast_sink = (ph == 2);
      fast_src = (ph == 2);
      for (int i = 0; i < 200; i++) begin
        r = $urandom_range(0, 99);
        if (r < (ph == 1 ? 60 : 35)) c = CMD_ADD;
        else if (r < 65) c = CMD_REMOVE;
        else if (r < 97) c = CMD_CHANGE;
        else c = CmdSpare;
        send_word(c, IdW'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom),
                  PrioW'($urandom));
      end
      fast_sink = 1'b0;
      fast_src = 1'b0;
      if (ph == 1) drain();
    end
    drain();
    if (fail_count == 0) $display("** priority_ready_queue: PASSED **");
    else $display("** priority_ready_queue: FAILED **");
    $finish;
  end

endmodule
